// ----- rtl/lz4d_pkg.sv -----
// ----------------------------------------------------------------------------
// LZ4 block decompressor package
// Payload words, parser-to-executor command word and status codes.
// ----------------------------------------------------------------------------
package lz4d_pkg;

   localparam int MIN_MATCH = 4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_OFF  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_TRUNC    = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } in_type;

   typedef struct packed {
      logic [63:0] out_data;
      logic [3:0]  out_count;
      logic [1:0]  out_status;
      logic        out_block_end;
      logic        out_run_last;
   } out_type;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_COPY,
      CMD_STATUS
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   lit_byte;
      logic [7:0]   len;
      logic [15:0]  offset;
      logic [1:0]   status;
      logic         block_end;
   } cmd_type;

endpackage

// ----- rtl/lz4d_parser.sv -----
// ----------------------------------------------------------------------------
// LZ4 sequence parser
// Parses tokens, length extensions, literals and offsets; checks errors and
// issues at most one command word per input byte.
// ----------------------------------------------------------------------------
module lz4d_parser #(
   parameter int WINDOW_BYTES = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  lz4d_pkg::in_type in_item,
   input  logic             in_valid,
   input  logic [31:0]      capacity,
   output logic             cmd_valid,
   output lz4d_pkg::cmd_type cmd
);
   import lz4d_pkg::*;

   typedef enum logic [2:0] {
      PH_TOKEN, PH_LIT_EXT, PH_LITERALS, PH_OFF_LO, PH_OFF_HI, PH_MAT_EXT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  nib_ff, nib_in;
   logic [31:0] lit_ff, lit_in;
   logic [7:0]  off_lo_ff, off_lo_in;
   logic [7:0]  off_hi_keep_ff, off_hi_keep_in, off_hi_keep;
   logic [31:0] prod_ff, prod_in;
   logic        skip_ff, skip_in;

   logic [7:0]  b;
   logic        last;
   logic [32:0] lit_sum;
   logic [31:0] lit_sat;
   logic [15:0] offset;
   logic [7:0]  mlen;
   logic        failed;
   logic [1:0]  fail_status;

   function automatic logic too_big(input logic [31:0] p, input logic [31:0] extra,
                                    input logic [31:0] cap);
      return ({1'b0, p} + {1'b0, extra}) > {1'b0, cap};
   endfunction

   assign b       = in_item.in_byte;
   assign last    = in_item.in_last;
   assign lit_sum = {1'b0, lit_ff} + {25'd0, b};
   assign lit_sat = lit_sum[32] ? 32'hFFFF_FFFF : lit_sum[31:0];
   assign offset  = {b, off_lo_ff};
   assign mlen    = 8'({4'd0, nib_ff} + 8'(MIN_MATCH));

   always_comb begin
      phase_in    = phase_ff;
      nib_in      = nib_ff;
      lit_in      = lit_ff;
      off_lo_in   = off_lo_ff;
      prod_in     = prod_ff;
      skip_in     = skip_ff;
      cmd_valid   = 1'b0;
      cmd         = '0;
      cmd.kind    = CMD_STATUS;
      failed      = 1'b0;
      fail_status = ST_OK;
      if (in_valid) begin
         if (skip_ff) begin
            if (last) skip_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_LIT_EXT: begin
                  lit_in = lit_sat;
                  if (too_big(prod_ff, lit_sat, capacity)) begin
                     failed = 1'b1; fail_status = ST_OVERFLOW;
                  end else if (b != 8'hFF) begin
                     phase_in = PH_LITERALS;
                  end
               end
               PH_LITERALS: begin
                  if (last && lit_ff > 32'd1) begin
                     failed = 1'b1; fail_status = ST_TRUNC;
                  end else begin
                     cmd_valid    = 1'b1;
                     cmd.kind     = CMD_LIT;
                     cmd.lit_byte = b;
                     prod_in      = prod_ff + 32'd1;
                     lit_in       = (lit_ff != 32'd0) ? lit_ff - 32'd1 : lit_ff;
                     if (lit_ff <= 32'd1) phase_in = PH_OFF_LO;
                  end
               end
               PH_OFF_LO: begin
                  off_lo_in = b;
                  phase_in  = PH_OFF_HI;
               end
               PH_OFF_HI: begin
                  if (offset == 16'd0 || {16'd0, offset} > prod_ff
                      || {1'b0, offset} > 17'(WINDOW_BYTES)) begin
                     failed = 1'b1; fail_status = ST_BAD_OFF;
                  end else if (too_big(prod_ff, {24'd0, mlen}, capacity)) begin
                     failed = 1'b1; fail_status = ST_OVERFLOW;
                  end else if (last && nib_ff == 4'hF) begin
                     failed = 1'b1; fail_status = ST_TRUNC;
                  end else begin
                     cmd_valid  = 1'b1;
                     cmd.kind   = CMD_COPY;
                     cmd.len    = mlen;
                     cmd.offset = offset;
                     prod_in    = prod_ff + {24'd0, mlen};
                     phase_in   = (nib_ff == 4'hF) ? PH_MAT_EXT : PH_TOKEN;
                  end
               end
               PH_MAT_EXT: begin
                  if (too_big(prod_ff, {24'd0, b}, capacity)) begin
                     failed = 1'b1; fail_status = ST_OVERFLOW;
                  end else if (last && b == 8'hFF) begin
                     failed = 1'b1; fail_status = ST_TRUNC;
                  end else begin
                     if (b != 8'd0) begin
                        cmd_valid  = 1'b1;
                        cmd.kind   = CMD_COPY;
                        cmd.len    = b;
                        cmd.offset = {off_hi_keep, off_lo_ff};
                     end
                     prod_in = prod_ff + {24'd0, b};
                     if (b != 8'hFF) phase_in = PH_TOKEN;
                  end
               end
               default: begin
                  nib_in = b[3:0];
                  lit_in = {28'd0, b[7:4]};
                  if (too_big(prod_ff, {28'd0, b[7:4]}, capacity)) begin
                     failed = 1'b1; fail_status = ST_OVERFLOW;
                  end else if (b[7:4] == 4'hF) begin
                     phase_in = PH_LIT_EXT;
                  end else if (b[7:4] != 4'd0) begin
                     phase_in = PH_LITERALS;
                  end else begin
                     phase_in = PH_OFF_LO;
                  end
               end
            endcase
            if (!failed && last) begin
               if (phase_in != PH_OFF_LO && phase_in != PH_TOKEN) begin
                  failed = 1'b1; fail_status = ST_TRUNC;
               end else begin
                  if (!cmd_valid) begin
                     cmd_valid = 1'b1;
                     cmd       = '0;
                     cmd.kind  = CMD_STATUS;
                  end
                  cmd.block_end = 1'b1;
                  phase_in = PH_TOKEN;
                  nib_in   = '0;
                  lit_in   = '0;
                  prod_in  = '0;
               end
            end
            if (failed) begin
               cmd_valid     = 1'b1;
               cmd           = '0;
               cmd.kind      = CMD_STATUS;
               cmd.status    = fail_status;
               cmd.block_end = 1'b1;
               phase_in      = PH_TOKEN;
               nib_in        = '0;
               lit_in        = '0;
               prod_in       = '0;
               skip_in       = !last;
            end
         end
      end
   end

   assign off_hi_keep    = off_hi_keep_ff;
   assign off_hi_keep_in = (in_valid && !skip_ff && phase_ff == PH_OFF_HI) ? b
                                                                          : off_hi_keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TOKEN;
         nib_ff   <= '0;
         lit_ff   <= '0;
         prod_ff  <= '0;
         skip_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         nib_ff   <= nib_in;
         lit_ff   <= lit_in;
         prod_ff  <= prod_in;
         skip_ff  <= skip_in;
      end
      off_lo_ff      <= off_lo_in;
      off_hi_keep_ff <= off_hi_keep_in;
   end

endmodule

// ----- rtl/lz4d_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// LZ4 command queue
// Four-entry queue between parser and executor.
// ----------------------------------------------------------------------------
module lz4d_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  lz4d_pkg::cmd_type wr_cmd,
   output logic              full,
   input  logic              rd_en,
   output lz4d_pkg::cmd_type rd_cmd,
   output logic              empty
);
   import lz4d_pkg::*;

   cmd_type    slot_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;

   assign full   = (count_ff == 3'd4);
   assign empty  = (count_ff == 3'd0);
   assign rd_cmd = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + {2'd0, wr_en} - {2'd0, rd_en};
      end
      if (wr_en) slot_ff[wr_ptr_ff] <= wr_cmd;
   end

endmodule

// ----- rtl/lz4d_exec.sv -----
// ----------------------------------------------------------------------------
// LZ4 command executor
// Writes literals to history, copies matches byte by byte and packs beats.
// ----------------------------------------------------------------------------
module lz4d_exec #(
   parameter int WINDOW_BYTES = 65536,
   parameter int BEAT_BYTES   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  lz4d_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output lz4d_pkg::out_type out_item,
   output logic              out_empty,
   input  logic              out_pop
);
   import lz4d_pkg::*;

   localparam int AW = $clog2(WINDOW_BYTES);

   typedef enum logic [1:0] {S_IDLE, S_RD, S_WR, S_EMIT} state_type;

   logic [7:0]    mem [WINDOW_BYTES];
   logic [7:0]    rdata_ff;
   logic          we;
   logic [AW-1:0] wa, ra;
   logic [7:0]    wd;

   state_type     state_ff;
   logic [AW-1:0] wp_ff, rp_ff;
   logic [7:0]    rem_ff;
   logic [63:0]   data_ff;
   logic [3:0]    cnt_ff;
   logic [1:0]    status_ff;
   logic          end_ff;
   out_type       out_ff;
   logic          out_valid_ff;
   logic          out_free;

   assign out_free  = !out_valid_ff || out_pop;
   assign out_item  = out_ff;
   assign out_empty = !out_valid_ff;
   assign cmd_pop   = (state_ff == S_IDLE) && !cmd_empty;

   always_comb begin
      we = 1'b0;
      wa = wp_ff;
      wd = rdata_ff;
      ra = rp_ff;
      if (state_ff == S_IDLE && !cmd_empty && cmd.kind == CMD_LIT) begin
         we = 1'b1;
         wd = cmd.lit_byte;
      end else if (state_ff == S_WR) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rdata_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         wp_ff        <= '0;
      end else begin
         if (out_pop) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  data_ff   <= '0;
                  cnt_ff    <= '0;
                  status_ff <= cmd.status;
                  end_ff    <= cmd.block_end;
                  rem_ff    <= '0;
                  case (cmd.kind)
                     CMD_LIT: begin
                        data_ff  <= {56'd0, cmd.lit_byte};
                        cnt_ff   <= 4'd1;
                        wp_ff    <= wp_ff + AW'(1);
                        state_ff <= S_EMIT;
                     end
                     CMD_COPY: begin
                        rem_ff   <= cmd.len;
                        rp_ff    <= wp_ff - cmd.offset[AW-1:0];
                        state_ff <= S_RD;
                     end
                     default: state_ff <= S_EMIT;
                  endcase
               end
            end
            S_RD: begin
               rp_ff    <= rp_ff + AW'(1);
               state_ff <= S_WR;
            end
            S_WR: begin
               data_ff  <= data_ff | ({56'd0, rdata_ff} << {cnt_ff, 3'd0});
               cnt_ff   <= cnt_ff + 4'd1;
               rem_ff   <= rem_ff - 8'd1;
               wp_ff    <= wp_ff + AW'(1);
               state_ff <= (cnt_ff == 4'(BEAT_BYTES - 1) || rem_ff == 8'd1) ? S_EMIT
                                                                            : S_RD;
            end
            S_EMIT: begin
               if (out_free) begin
                  out_valid_ff         <= 1'b1;
                  out_ff.out_data      <= data_ff;
                  out_ff.out_count     <= cnt_ff;
                  out_ff.out_status    <= status_ff;
                  out_ff.out_block_end <= end_ff && (rem_ff == 8'd0);
                  out_ff.out_run_last  <= (rem_ff == 8'd0);
                  data_ff              <= '0;
                  cnt_ff               <= '0;
                  state_ff             <= (rem_ff == 8'd0) ? S_IDLE : S_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/lz4_block_decompressor.sv -----
// ----------------------------------------------------------------------------
// LZ4 block decompressor
// Parser, command queue and history executor with an APB register port.
// ----------------------------------------------------------------------------
// A compressed byte is taken each cycle while the command queue has room;
// token, offset and literal-length bytes produce no output bytes. The executor
// takes each command in its idle state; a literal then goes to the emit state,
// and each match byte passes through a history read state, then a write state.
// Each result beat of up to BEAT_BYTES bytes leaves from the emit state. The
// registered history read ahead of each copied byte's write is why a match
// byte needs both states. After an error the block's emitted bytes are void.
module lz4_block_decompressor #(
   parameter int WINDOW_BYTES = 65536,
   parameter int BEAT_BYTES   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lz4d_pkg::in_type  req_item,
   output logic              empty,
   input  logic              pop,
   output lz4d_pkg::out_type rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import lz4d_pkg::*;

   logic [31:0] cap_ff;
   logic        cmd_valid, fifo_full, fifo_empty, cmd_pop, accept;
   cmd_type     cmd_w, cmd_r;

   assign pready = 1'b1;
   assign prdata = (paddr == 3'd0) ? cap_ff : 32'd0;
   assign full   = fifo_full;
   assign accept = push && !fifo_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 32'd65536;
      end else if (psel && penable && pwrite && paddr == 3'd0) begin
         cap_ff <= pwdata;
      end
   end

   lz4d_parser #(.WINDOW_BYTES(WINDOW_BYTES)) u_parser (
      .clock(clock), .reset(reset), .in_item(req_item), .in_valid(accept),
      .capacity(cap_ff), .cmd_valid(cmd_valid), .cmd(cmd_w)
   );

   lz4d_cmd_fifo u_fifo (
      .clock(clock), .reset(reset), .wr_en(cmd_valid), .wr_cmd(cmd_w),
      .full(fifo_full), .rd_en(cmd_pop), .rd_cmd(cmd_r), .empty(fifo_empty)
   );

   lz4d_exec #(.WINDOW_BYTES(WINDOW_BYTES), .BEAT_BYTES(BEAT_BYTES)) u_exec (
      .clock(clock), .reset(reset), .cmd(cmd_r), .cmd_empty(fifo_empty),
      .cmd_pop(cmd_pop), .out_item(rsp_item), .out_empty(empty), .out_pop(pop)
   );

   a_err_status_only: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.out_status != ST_OK) |->
         (rsp_item.out_count == 4'd0 && rsp_item.out_block_end))
      else $error("error result carries data");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.out_count <= 4'(BEAT_BYTES)))
      else $error("beat count too large");

   a_empty_ends_block: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.out_count == 4'd0) |->
         (rsp_item.out_block_end && rsp_item.out_run_last))
      else $error("status result without block end");

endmodule

// ----- verif/lz4_block_decompressor_chk.sv -----
// ----------------------------------------------------------------------------
// LZ4 block decompressor checker
// Watches the byte, result and register channels. Decodes each accepted
// compressed byte into the result words it must produce and compares every
// popped word with the oldest one still owed.
// ----------------------------------------------------------------------------
module lz4_block_decompressor_chk (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  lz4d_pkg::in_type  req_item,
   input  logic              empty,
   input  logic              pop,
   input  lz4d_pkg::out_type rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                words_owed,
   output int                fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import lz4d_pkg::*;

   localparam int WINDOW   = 65536;
   localparam int BEAT     = 8;
   localparam logic [2:0] REG_CAPACITY = 3'd0;

   typedef enum logic [2:0] {
      PH_TOKEN, PH_LIT_EXT, PH_LITERALS, PH_OFF_LO, PH_OFF_HI, PH_MAT_EXT
   } phase_type;

   out_type     owed_words[$];
   out_type     run_words[$];
   logic [7:0]  window_mem [0:WINDOW-1];
   phase_type   phase;
   logic [3:0]  nibble;
   logic [31:0] lits_left;
   logic [15:0] offset;
   logic [31:0] produced;
   logic        skip;
   logic [31:0] capacity;

   assign words_owed = owed_words.size();

   task automatic clear_parse();
      phase = PH_TOKEN;
      nibble = '0;
      lits_left = '0;
      offset = '0;
      produced = '0;
   endtask

   function automatic bit exceeds(logic [31:0] extra);
      return 33'(produced) + 33'(extra) > 33'(capacity);
   endfunction

   task automatic add_word(logic [63:0] data, logic [3:0] count, logic [1:0] status);
      out_type w;
      w.out_data = data;
      w.out_count = count;
      w.out_status = status;
      w.out_block_end = 1'b0;
      w.out_run_last = 1'b0;
      run_words.push_back(w);
   endtask

   task automatic abort_block(logic [1:0] status, logic last);
      out_type w;
      w = '0;
      w.out_status = status;
      w.out_block_end = 1'b1;
      w.out_run_last = 1'b1;
      owed_words.push_back(w);
      clear_parse();
      skip = !last;
   endtask

   task automatic copy_back(int len);
      logic [63:0] data;
      logic [7:0]  b;
      int          c;
      int          done;
      done = 0;
      while (done < len) begin
         data = '0;
         c = 0;
         while (c < BEAT && done < len) begin
            b = window_mem[16'(produced - 32'(offset))];
            window_mem[16'(produced)] = b;
            data[8*c +: 8] = b;
            c++;
            done++;
            produced++;
         end
         add_word(data, 4'(c), ST_OK);
      end
   endtask

   task automatic decode_byte(logic [7:0] b, logic last);
      run_words.delete();
      if (skip) begin
         if (last)
            skip = 1'b0;
         return;
      end
      case (phase)
         PH_LIT_EXT: begin
            lits_left = (lits_left > 32'hFFFF_FFFF - 32'(b)) ? 32'hFFFF_FFFF
                                                             : lits_left + 32'(b);
            if (exceeds(lits_left)) begin
               abort_block(ST_OVERFLOW, last);
               return;
            end
            if (b != 8'd255)
               phase = PH_LITERALS;
         end
         PH_LITERALS: begin
            if (last && lits_left > 1) begin
               abort_block(ST_TRUNC, last);
               return;
            end
            window_mem[16'(produced)] = b;
            produced++;
            add_word(64'(b), 4'd1, ST_OK);
            if (lits_left > 0)
               lits_left--;
            if (lits_left == 0)
               phase = PH_OFF_LO;
         end
         PH_OFF_LO: begin
            offset = 16'(b);
            phase = PH_OFF_HI;
         end
         PH_OFF_HI: begin
            offset[15:8] = b;
            if (offset == 0 || 32'(offset) > produced) begin
               abort_block(ST_BAD_OFF, last);
               return;
            end
            if (exceeds(32'(nibble) + MIN_MATCH)) begin
               abort_block(ST_OVERFLOW, last);
               return;
            end
            if (last && nibble == 4'd15) begin
               abort_block(ST_TRUNC, last);
               return;
            end
            copy_back(int'(nibble) + MIN_MATCH);
            phase = (nibble == 4'd15) ? PH_MAT_EXT : PH_TOKEN;
         end
         PH_MAT_EXT: begin
            if (exceeds(32'(b))) begin
               abort_block(ST_OVERFLOW, last);
               return;
            end
            if (last && b == 8'd255) begin
               abort_block(ST_TRUNC, last);
               return;
            end
            copy_back(int'(b));
            if (b != 8'd255)
               phase = PH_TOKEN;
         end
         default: begin
            nibble = b[3:0];
            lits_left = 32'(b[7:4]);
            if (exceeds(lits_left)) begin
               abort_block(ST_OVERFLOW, last);
               return;
            end
            if (lits_left == 15)
               phase = PH_LIT_EXT;
            else if (lits_left > 0)
               phase = PH_LITERALS;
            else
               phase = PH_OFF_LO;
         end
      endcase
      if (last) begin
         if (phase != PH_OFF_LO && phase != PH_TOKEN) begin
            abort_block(ST_TRUNC, last);
            return;
         end
         if (run_words.size() == 0)
            add_word('0, 4'd0, ST_OK);
         run_words[run_words.size()-1].out_block_end = 1'b1;
         clear_parse();
      end
      if (run_words.size() > 0)
         run_words[run_words.size()-1].out_run_last = 1'b1;
      foreach (run_words[i])
         owed_words.push_back(run_words[i]);
   endtask

   task automatic check_word(out_type got);
      out_type want;
      if (owed_words.size() == 0) begin
         $error("unexpected word data %h count %0d", got.out_data, got.out_count);
         fail_count++;
         return;
      end
      want = owed_words.pop_front();
      if (got.out_data !== want.out_data) begin
         $error("out_data exp %h got %h", want.out_data, got.out_data);
         fail_count++;
      end
      if (got.out_count !== want.out_count) begin
         $error("out_count exp %0d got %0d", want.out_count, got.out_count);
         fail_count++;
      end
      if (got.out_status !== want.out_status) begin
         $error("out_status exp %0d got %0d", want.out_status, got.out_status);
         fail_count++;
      end
      if (got.out_block_end !== want.out_block_end) begin
         $error("out_block_end exp %0b got %0b", want.out_block_end, got.out_block_end);
         fail_count++;
      end
      if (got.out_run_last !== want.out_run_last) begin
         $error("out_run_last exp %0b got %0b", want.out_run_last, got.out_run_last);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         owed_words.delete();
         clear_parse();
         skip = 1'b0;
         capacity = 32'd65536;
      end else begin
         if (pop && !empty)
            check_word(rsp_item);
         if (psel && penable && pwrite && pready && paddr == REG_CAPACITY)
            capacity = pwdata;
         if (push && !full)
            decode_byte(req_item.in_byte, req_item.in_last);
      end
   end

endmodule

// ----- verif/lz4_block_decompressor_tb.sv -----
// ----------------------------------------------------------------------------
// LZ4 block decompressor testbench
// Feeds directed and random compressed blocks, clean and broken, through
// several output capacities with bursty input and a stalling receiver;
// the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module lz4_block_decompressor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lz4d_pkg::*;

   localparam logic [2:0] REG_CAPACITY = 3'd0;
   localparam int DRAIN_CYCLES = 800;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   in_type      req_item;
   logic        empty;
   logic        pop;
   out_type     rsp_item;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          words_owed;
   int          fail_count;
   int          burst_left;
   int          stall_pct;
   int          stall_cycles;
   logic [7:0]  block_bytes[$];

   lz4_block_decompressor u_top (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   lz4_block_decompressor_chk u_chk (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .words_owed(words_owed), .fail_count(fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_cycles == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 30;
            2: stall_pct <= 70;
            default: stall_pct <= 95;
         endcase
         stall_cycles <= $urandom_range(20, 300);
      end else begin
         stall_cycles <= stall_cycles - 1;
      end
      pop <= reset ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push <= 1'b1;
      req_item <= '{in_byte: b, in_last: last};
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic send_block();
      foreach (block_bytes[i])
         send_byte(block_bytes[i], i == block_bytes.size() - 1);
   endtask

   task automatic add_length(int rest);
      while (rest >= 255) begin
         block_bytes.push_back(8'd255);
         rest -= 255;
      end
      block_bytes.push_back(8'(rest));
   endtask

   task automatic make_block(bit broken);
      int nseq;
      int lits;
      int extra;
      int made;
      int off;
      int cut;
      block_bytes.delete();
      made = 0;
      nseq = $urandom_range(1, 3);
      for (int s = 0; s < nseq; s++) begin
         lits = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
         if (made + lits == 0)
            lits = 1;
         extra = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 290) : $urandom_range(0, 10);
         block_bytes.push_back({4'(lits >= 15 ? 15 : lits), 4'(extra >= 15 ? 15 : extra)});
         if (lits >= 15)
            add_length(lits - 15);
         repeat (lits) block_bytes.push_back(8'($urandom));
         made += lits;
         if (s == nseq - 1 && $urandom_range(0, 1) == 0) begin
            block_bytes[block_bytes.size() - 1 - lits - (lits >= 15 ? 1 + (lits - 15) / 255 : 0)]
               [3:0] = 4'd0;
            break;
         end
         off = $urandom_range(1, made > 65535 ? 65535 : made);
         block_bytes.push_back(8'(off));
         block_bytes.push_back(8'(off >> 8));
         if (extra >= 15)
            add_length(extra - 15);
         made += extra + MIN_MATCH;
      end
      if (broken) begin
         case ($urandom_range(0, 2))
            0: begin
               cut = $urandom_range(1, block_bytes.size());
               while (block_bytes.size() > cut) void'(block_bytes.pop_back());
            end
            1: block_bytes[$urandom_range(0, block_bytes.size() - 1)] = 8'($urandom);
            default: begin
               block_bytes.delete();
               repeat ($urandom_range(1, 8)) block_bytes.push_back(8'($urandom));
            end
         endcase
      end
   endtask

   task automatic write_capacity(logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= REG_CAPACITY;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic settle();
      push <= 1'b0;
      while (words_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_list(logic [7:0] list[$]);
      block_bytes = list;
      send_block();
   endtask

   initial begin
      logic [31:0] capacities[5];
      int sent;
      capacities = '{32'hFFFF_FFFF, 32'd0, 32'd60, 32'd9, 32'd65536};
      reset = 1'b1;
      push = 1'b0;
      req_item = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_list('{8'h00});
      send_list('{8'h11, 8'h41, 8'h00, 8'h00, 8'h00});
      send_list('{8'h1F, 8'h5A, 8'h01, 8'h00, 8'hFF, 8'h03});
      send_list('{8'h1F, 8'hFF, 8'h01, 8'h00, 8'hFF});
      send_list('{8'h20, 8'h01, 8'hFE, 8'h05, 8'h00});
      settle();

      foreach (capacities[p]) begin
         write_capacity(capacities[p]);
         sent = 0;
         while (sent < 8) begin
            make_block($urandom_range(0, 3) == 0);
            sent += block_bytes.size();
            send_block();
         end
         settle();
      end

      if (fail_count == 0 && words_owed == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lz4d_pkg.sv
rtl/lz4d_parser.sv
rtl/lz4d_cmd_fifo.sv
rtl/lz4d_exec.sv
rtl/lz4_block_decompressor.sv
verif/lz4_block_decompressor_chk.sv
verif/lz4_block_decompressor_tb.sv
